/* hdl/wtat_pkg.sv */
// Shared types, codes and the pattern compare for the alarm table.
// Used by wtat_cell and wildcard_time_alarm_table; depends on nothing else.
package wtat_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam logic [7:0] ANY_VALUE = 8'hFF;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_NO_CHANGE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] slot;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       matched;
        logic [4:0] entry_index;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } pattern_t;

    localparam int PATTERN_W = $bits(pattern_t);

    // Control broadcast from the sequencer to every cell of the list.
    typedef struct packed {
        logic shift;
        logic append;
        logic update;
    } cell_ctrl_t;

    function automatic logic field_hit(input logic [7:0] p, input logic [7:0] v);
        return (p == ANY_VALUE) || (p == v);
    endfunction

    function automatic logic pattern_hit(input pattern_t p, input pattern_t now);
        return field_hit(p.year, now.year) && field_hit(p.month, now.month) &&
               field_hit(p.day, now.day) && field_hit(p.hour, now.hour) &&
               field_hit(p.minute, now.minute) && field_hit(p.second, now.second);
    endfunction

    function automatic pattern_t item_pattern(input in_item_t it);
        pattern_t p;
        p.year   = it.year;
        p.month  = it.month;
        p.day    = it.day;
        p.hour   = it.hour;
        p.minute = it.minute;
        p.second = it.second;
        return p;
    endfunction

endpackage

/* hdl/wtat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wtat_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/wtat_cell.sv */
// One position of the active list: holds a slot number and a copy of its pattern.
// Depends on wtat_pkg for the pattern and control types.
module wtat_cell
    import wtat_pkg::*;
#(
    parameter int SLOT_W = 5,
    parameter int LEN_W  = 6,
    parameter int INDEX  = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [LEN_W-1:0]  len,
    input  logic [SLOT_W-1:0] next_slot,
    input  pattern_t          next_pat,
    input  logic [SLOT_W-1:0] head_slot,
    input  pattern_t          head_pat,
    input  logic [SLOT_W-1:0] bus_slot,
    input  pattern_t          bus_pat,
    output logic [SLOT_W-1:0] slot,
    output pattern_t          pat
);

    logic [SLOT_W-1:0] slot_reg;
    pattern_t          pat_reg;
    logic              is_tail;
    logic              is_free;

    // The list occupies cells 0 to len-1; during a rotation the tail takes the head.
    assign is_tail = (len == LEN_W'(INDEX + 1));
    assign is_free = (len == LEN_W'(INDEX));

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            if (is_tail) begin
                slot_reg <= head_slot;
                pat_reg  <= head_pat;
            end else begin
                slot_reg <= next_slot;
                pat_reg  <= next_pat;
            end
        end else if (ctrl.append && is_free) begin
            slot_reg <= bus_slot;
            pat_reg  <= bus_pat;
        end else if (ctrl.update && slot_reg == bus_slot) begin
            pat_reg <= bus_pat;
        end
    end

    assign slot = slot_reg;
    assign pat  = pat_reg;

endmodule

/* hdl/wildcard_time_alarm_table.sv */
// Alarm pattern table with an ordered active list, top level.
// Depends on wtat_pkg, wtat_ram and wtat_cell.
//
// Usage:
//   Items enter on s_valid/s_ready/s_data and results leave on m_valid/m_ready/m_data.
//   A write stores a pattern, insert appends a slot to the active list, remove takes
//   a slot out, and a tick reports every active slot whose pattern matches the time,
//   in list order, with last set on the final result (or one no-match result).
//   The list lives in a ring of cells. A tick or a remove rotates the ring once,
//   one entry per cycle while a tick is not held by the output; an insert also
//   goes through a state for the pattern RAM read. One item is worked on at a
//   time; s_ready is high only while the block is between items.
//   Results sit in an output register; while the receiver holds m_ready low the
//   tick rotation stops and resumes when the result transfer completes, so nothing
//   is lost. The synchronous active-low reset empties the list, clears the written
//   count and makes every pattern read as zero; no clearing pass is needed.
module wildcard_time_alarm_table
    import wtat_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEN_W  = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0]         state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]  held_slot_reg, held_slot_next;
    logic [LEN_W-1:0]   active_len_reg, active_len_next;
    logic [LEN_W-1:0]   written_cnt_reg, written_cnt_next;
    logic [ENTRIES-1:0] active_flags_reg, active_flags_next;
    logic [ENTRIES-1:0] written_flags_reg, written_flags_next;
    logic [1:0]         status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    cell_ctrl_t         ctrl;
    logic [SLOT_W-1:0]  bus_slot;
    pattern_t           bus_pat;
    logic               ram_we;
    logic [PATTERN_W-1:0] ram_rdata;

    logic [SLOT_W-1:0]  cell_slot [ENTRIES];
    pattern_t           cell_pat  [ENTRIES];

    logic [SLOT_W-1:0]  in_idx;
    logic [SLOT_W-1:0]  item_idx;
    logic               in_range;
    logic               out_free;
    logic               head_hit;

    assign in_idx   = s_data.slot[SLOT_W-1:0];
    assign item_idx = item_reg.slot[SLOT_W-1:0];
    assign in_range = (s_data.slot < 8'(ENTRIES));
    assign out_free = !m_valid_reg || m_ready;
    assign head_hit = pattern_hit(cell_pat[0], item_pattern(item_reg));
    assign s_ready  = (state_reg == ST_IDLE);

    wtat_ram #(
        .WIDTH (PATTERN_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (PATTERN_W'(item_pattern(s_data))),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [SLOT_W-1:0] nbr_slot;
        pattern_t          nbr_pat;
        if (i == ENTRIES - 1) begin : g_end
            assign nbr_slot = cell_slot[0];
            assign nbr_pat  = cell_pat[0];
        end else begin : g_mid
            assign nbr_slot = cell_slot[i+1];
            assign nbr_pat  = cell_pat[i+1];
        end
        wtat_cell #(
            .SLOT_W (SLOT_W),
            .LEN_W  (LEN_W),
            .INDEX  (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .len       (active_len_reg),
            .next_slot (nbr_slot),
            .next_pat  (nbr_pat),
            .head_slot (cell_slot[0]),
            .head_pat  (cell_pat[0]),
            .bus_slot  (bus_slot),
            .bus_pat   (bus_pat),
            .slot      (cell_slot[i]),
            .pat       (cell_pat[i])
        );
    end

    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        cnt_next           = cnt_reg;
        held_valid_next    = held_valid_reg;
        held_slot_next     = held_slot_reg;
        active_len_next    = active_len_reg;
        written_cnt_next   = written_cnt_reg;
        active_flags_next  = active_flags_reg;
        written_flags_next = written_flags_reg;
        status_next        = status_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;
        ctrl               = '0;
        bus_slot           = item_idx;
        bus_pat            = item_pattern(item_reg);
        ram_we             = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                bus_slot = in_idx;
                bus_pat  = item_pattern(s_data);
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_RESP;
                    case (s_data.kind)
                        KIND_WRITE: begin
                            if (written_cnt_reg == LEN_W'(ENTRIES)) begin
                                status_next = STATUS_FULL;
                            end else if (!in_range) begin
                                status_next = STATUS_RANGE;
                            end else begin
                                ram_we                     = 1'b1;
                                ctrl.update                = 1'b1;
                                written_cnt_next           = written_cnt_reg + 1'b1;
                                written_flags_next[in_idx] = 1'b1;
                                status_next                = STATUS_DONE;
                            end
                        end
                        KIND_INSERT: begin
                            if (!in_range) begin
                                status_next = STATUS_RANGE;
                            end else if (active_flags_reg[in_idx] ||
                                         active_len_reg == LEN_W'(ENTRIES)) begin
                                status_next = STATUS_NO_CHANGE;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!in_range) begin
                                status_next = STATUS_RANGE;
                            end else if (!active_flags_reg[in_idx]) begin
                                status_next = STATUS_NO_CHANGE;
                            end else begin
                                active_flags_next[in_idx] = 1'b0;
                                cnt_next                  = active_len_reg;
                                state_next                = ST_SCAN;
                            end
                        end
                        default: begin
                            held_valid_next = 1'b0;
                            cnt_next        = active_len_reg;
                            state_next      = (active_len_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // Slots never written read as the reset pattern of all zeros.
                ctrl.append = 1'b1;
                bus_pat     = written_flags_reg[item_idx] ? pattern_t'(ram_rdata) : '0;
                active_len_next             = active_len_reg + 1'b1;
                active_flags_next[item_idx] = 1'b1;
                status_next                 = STATUS_DONE;
                state_next                  = ST_RESP;
            end
            ST_SCAN: begin
                if (item_reg.kind == KIND_TICK) begin
                    // A match is held back one step so that the final one can carry last.
                    if (out_free) begin
                        ctrl.shift = 1'b1;
                        cnt_next   = cnt_reg - 1'b1;
                        if (head_hit) begin
                            if (held_valid_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{status: STATUS_DONE, matched: 1'b1,
                                                 entry_index: 5'(held_slot_reg),
                                                 last: 1'b0};
                            end
                            held_valid_next = 1'b1;
                            held_slot_next  = cell_slot[0];
                        end
                        if (cnt_reg == LEN_W'(1)) begin
                            state_next = ST_FINISH;
                        end
                    end
                end else begin
                    // The removed entry is rotated to the tail and falls off the list.
                    ctrl.shift = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    if (cell_slot[0] == item_idx) begin
                        active_len_next = active_len_reg - 1'b1;
                    end
                    if (cnt_reg == LEN_W'(1)) begin
                        status_next = STATUS_DONE;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (held_valid_reg) begin
                        m_data_next = '{status: STATUS_DONE, matched: 1'b1,
                                        entry_index: 5'(held_slot_reg), last: 1'b1};
                    end else begin
                        m_data_next = '{status: STATUS_DONE, matched: 1'b0,
                                        entry_index: item_reg.slot[4:0], last: 1'b1};
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_reg, matched: 1'b0,
                                     entry_index: item_reg.slot[4:0], last: 1'b1};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            held_valid_reg    <= 1'b0;
            active_len_reg    <= '0;
            written_cnt_reg   <= '0;
            active_flags_reg  <= '0;
            written_flags_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            held_valid_reg    <= held_valid_next;
            active_len_reg    <= active_len_next;
            written_cnt_reg   <= written_cnt_next;
            active_flags_reg  <= active_flags_next;
            written_flags_reg <= written_flags_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        cnt_reg       <= cnt_next;
        held_slot_reg <= held_slot_next;
        status_reg    <= status_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_len_reg <= LEN_W'(ENTRIES))
        else $error("active list longer than the table");

    a_flags_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> $countones(active_flags_reg) == int'(active_len_reg))
        else $error("active flags disagree with the list length");

    a_written_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> written_cnt_reg >= $past(written_cnt_reg))
        else $error("written count went down");

    a_match_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.matched |-> m_data_reg.status == STATUS_DONE)
        else $error("match result with a nonzero status");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.last |-> state_reg == ST_SCAN || state_reg == ST_FINISH)
        else $error("non-final result outside a tick scan");
`endif

endmodule
